// ===== src/tpi_pkg.sv =====
`timescale 1ns / 1ps

package tpi_pkg;

    // Default number format of every coordinate and coefficient.
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Width of the threshold register.
    localparam int CFG_BITS = 32;

    // Columns of the extended system matrix; column E holds the negated constant term.
    localparam int NUM_COLS = 4;
    localparam logic [1:0] COL_A = 2'd0;
    localparam logic [1:0] COL_B = 2'd1;
    localparam logic [1:0] COL_C = 2'd2;
    localparam logic [1:0] COL_E = 2'd3;

    // 2x2 minors over planes two and three, one for each pair of columns X < Y:
    // minor(X, Y) = X[1] * Y[2] - Y[1] * X[2].
    localparam int NUM_MINORS = 6;
    localparam logic [2:0] MINOR_AB = 3'd0;
    localparam logic [2:0] MINOR_AC = 3'd1;
    localparam logic [2:0] MINOR_AE = 3'd2;
    localparam logic [2:0] MINOR_BC = 3'd3;
    localparam logic [2:0] MINOR_BE = 3'd4;
    localparam logic [2:0] MINOR_CE = 3'd5;

    localparam logic [1:0] MINOR_X [NUM_MINORS] = '{COL_A, COL_A, COL_A, COL_B, COL_B, COL_C};
    localparam logic [1:0] MINOR_Y [NUM_MINORS] = '{COL_B, COL_C, COL_E, COL_C, COL_E, COL_E};

    // Four determinants are formed: the system determinant and three numerators.
    localparam int NUM_SUMS = 4;
    localparam int SUM_DET  = 0;
    localparam int SUM_X    = 1;
    localparam int SUM_Y    = 2;
    localparam int SUM_Z    = 3;

    // Expansion along plane one: three terms per determinant, in sum order.
    localparam int NUM_TERMS = 12;
    localparam logic [1:0] TERM_COEF [NUM_TERMS] = '{
        COL_A, COL_B, COL_C,
        COL_E, COL_B, COL_C,
        COL_A, COL_E, COL_C,
        COL_A, COL_B, COL_E
    };
    localparam logic [2:0] TERM_MINOR [NUM_TERMS] = '{
        MINOR_BC, MINOR_AC, MINOR_AB,
        MINOR_BC, MINOR_CE, MINOR_BE,
        MINOR_CE, MINOR_AC, MINOR_AE,
        MINOR_BE, MINOR_AE, MINOR_AB
    };
    localparam logic TERM_NEG [NUM_TERMS] = '{
        1'b0, 1'b1, 1'b0,
        1'b0, 1'b0, 1'b1,
        1'b1, 1'b1, 1'b0,
        1'b0, 1'b1, 1'b0
    };

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SINGULAR  = 2'd1,
        STATUS_SATURATED = 2'd2
    } status_t;

endpackage

// ===== src/three_plane_intersection_unit.sv =====
`timescale 1ns / 1ps

// Intersection point of three planes a*x + b*y + c*z + d = 0 by Cramer's rule, in
// signed fixed point (WORD_BITS wide, FRAC_BITS fraction bits). The system
// determinant and the three numerators are formed exactly at full width. Planes
// whose determinant is zero or smaller in magnitude than min_determinant (in
// input units) come back as singular with a zero point; otherwise each
// coordinate is the numerator divided by the determinant, truncated toward
// zero, and clamped to the word range, with the saturated status when any
// coordinate was clamped. The block is a single pipeline with no state between
// items: a new transfer can be accepted every clock cycle while no finished
// result is held at the output. The divider resolves one quotient bit per
// stage for each coordinate; ahead of it sit two stages of 2x2 minors, three
// stages of cofactor expansion and one stage for magnitudes and the singular
// check. A stall on the result side freezes the whole pipeline; plane_stall
// follows it only while a finished result is waiting at the output.
// min_determinant resets to one and should only be written while no transfer
// is in flight.
module three_plane_intersection_unit
    import tpi_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_write_en,
    input  logic [CFG_BITS-1:0]         cfg_write_data,

    input  logic                        plane_valid,
    output logic                        plane_stall,
    input  logic signed [WORD_BITS-1:0] plane1_a,
    input  logic signed [WORD_BITS-1:0] plane1_b,
    input  logic signed [WORD_BITS-1:0] plane1_c,
    input  logic signed [WORD_BITS-1:0] plane1_d,
    input  logic signed [WORD_BITS-1:0] plane2_a,
    input  logic signed [WORD_BITS-1:0] plane2_b,
    input  logic signed [WORD_BITS-1:0] plane2_c,
    input  logic signed [WORD_BITS-1:0] plane2_d,
    input  logic signed [WORD_BITS-1:0] plane3_a,
    input  logic signed [WORD_BITS-1:0] plane3_b,
    input  logic signed [WORD_BITS-1:0] plane3_c,
    input  logic signed [WORD_BITS-1:0] plane3_d,

    output logic                        point_valid,
    input  logic                        point_stall,
    output logic signed [WORD_BITS-1:0] point_x,
    output logic signed [WORD_BITS-1:0] point_y,
    output logic signed [WORD_BITS-1:0] point_z,
    output logic [1:0]                  result_status
);

    localparam int CW   = WORD_BITS + 1;
    localparam int MW   = 2 * CW + 1;
    localparam int DW   = 3 * CW + 3;
    localparam int THW  = CFG_BITS + 2 * FRAC_BITS;
    localparam int CMPW = (DW > THW) ? DW : THW;
    // Five stages before the magnitude stage, the magnitude stage itself,
    // WORD_BITS + 1 divider stages and the output register.
    localparam int LAT  = WORD_BITS + 8;
    localparam int SGL  = WORD_BITS + 2;

    localparam logic [WORD_BITS-1:0] HALF    = WORD_BITS'(1) << (WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] SAT_MAX = HALF - WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] SAT_MIN = HALF;

    // Pipeline control.
    logic en;
    logic vld_reg  [LAT];
    logic vld_next [LAT];

    logic [CFG_BITS-1:0] min_det_reg;
    logic [CFG_BITS-1:0] min_det_next;

    // Front end.
    logic signed [WORD_BITS-1:0] coef_a [3];
    logic signed [WORD_BITS-1:0] coef_b [3];
    logic signed [WORD_BITS-1:0] coef_c [3];
    logic signed [WORD_BITS-1:0] coef_d [3];
    logic signed [MW-1:0]        minor  [NUM_MINORS];
    logic signed [CW-1:0]        row0   [NUM_COLS];
    logic signed [DW-1:0]        sums   [NUM_SUMS];

    // Magnitude stage.
    logic [DW-1:0]   det_mag;
    logic            det_neg;
    logic [CMPW-1:0] thr;
    logic [DW-1:0]   dmag_reg;
    logic [DW-1:0]   dmag_next;
    logic [DW-1:0]   nmag_reg  [3];
    logic [DW-1:0]   nmag_next [3];
    logic            cneg_reg  [3];
    logic            cneg_next [3];
    logic            sing_reg  [SGL];
    logic            sing_next [SGL];

    // Divider results.
    logic [WORD_BITS-1:0] quo     [3];
    logic                 ovf     [3];
    logic                 quo_neg [3];

    // Output stage.
    logic [WORD_BITS-1:0] coord     [3];
    logic                 coord_sat [3];
    logic [WORD_BITS-1:0] pt_reg  [3];
    logic [WORD_BITS-1:0] pt_next [3];
    status_t              status_reg;
    status_t              status_next;

    // The whole pipeline moves unless a finished result is held at the output.
    assign en          = !vld_reg[LAT-1] || !point_stall;
    assign plane_stall = !en;

    always_comb
    begin
        vld_next[0] = plane_valid;
        for (int i = 1; i < LAT; i++)
        begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Threshold register; the user must write it only while the pipeline is empty, the block does not enforce this.
    assign min_det_next = cfg_write_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_det_reg <= CFG_BITS'(1);
        end
        else if (cfg_write_en)
        begin
            min_det_reg <= min_det_next;
        end
    end

    assign coef_a = '{plane1_a, plane2_a, plane3_a};
    assign coef_b = '{plane1_b, plane2_b, plane3_b};
    assign coef_c = '{plane1_c, plane2_c, plane3_c};
    assign coef_d = '{plane1_d, plane2_d, plane3_d};

    tpi_minor #(
        .WORD_BITS (WORD_BITS)
    ) u_minor (
        .clk    (clk),
        .en     (en),
        .coef_a (coef_a),
        .coef_b (coef_b),
        .coef_c (coef_c),
        .coef_d (coef_d),
        .minor  (minor),
        .row0   (row0)
    );

    tpi_expand #(
        .WORD_BITS (WORD_BITS)
    ) u_expand (
        .clk   (clk),
        .en    (en),
        .minor (minor),
        .row0  (row0),
        .sums  (sums)
    );

    // Magnitudes for the unsigned divider, quotient signs, and the singular
    // check. The raw determinant carries three times the fraction bits, so the
    // threshold is scaled up by twice the fraction bits before the compare.
    always_comb
    begin
        det_neg   = sums[SUM_DET][DW-1];
        det_mag   = det_neg ? $unsigned(-sums[SUM_DET]) : $unsigned(sums[SUM_DET]);
        thr       = CMPW'(min_det_reg) << (2 * FRAC_BITS);
        dmag_next = det_mag;
        sing_next[0] = (sums[SUM_DET] == '0) || (CMPW'(det_mag) < thr);
        for (int i = 0; i < 3; i++)
        begin
            nmag_next[i] = sums[SUM_X+i][DW-1] ? $unsigned(-sums[SUM_X+i])
                                               : $unsigned(sums[SUM_X+i]);
            cneg_next[i] = sums[SUM_X+i][DW-1] ^ det_neg;
        end
        for (int i = 1; i < SGL; i++)
        begin
            sing_next[i] = sing_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg <= dmag_next;
            nmag_reg <= nmag_next;
            cneg_reg <= cneg_next;
            sing_reg <= sing_next;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        tpi_div #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .num_mag (nmag_reg[i]),
            .den_mag (dmag_reg),
            .neg     (cneg_reg[i]),
            .quo     (quo[i]),
            .ovf     (ovf[i]),
            .quo_neg (quo_neg[i])
        );
    end

    // Sign and clamp. A negative result may reach one step further than a
    // positive one, so the limit depends on the sign.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            coord_sat[i] = ovf[i] || (quo_neg[i] ? (quo[i] > HALF) : (quo[i] >= HALF));
            if (coord_sat[i])
                coord[i] = quo_neg[i] ? SAT_MIN : SAT_MAX;
            else
                coord[i] = quo_neg[i] ? (WORD_BITS'(0) - quo[i]) : quo[i];
        end

        if (sing_reg[SGL-1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pt_next[i] = '0;
            end
            status_next = STATUS_SINGULAR;
        end
        else
        begin
            pt_next     = coord;
            status_next = (coord_sat[0] || coord_sat[1] || coord_sat[2])
                        ? STATUS_SATURATED : STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg     <= pt_next;
            status_reg <= status_next;
        end
    end

    assign point_valid   = vld_reg[LAT-1];
    assign point_x       = $signed(pt_reg[0]);
    assign point_y       = $signed(pt_reg[1]);
    assign point_z       = $signed(pt_reg[2]);
    assign result_status = status_reg;

`ifndef SYNTH
    // Singular planes always carry a zero point.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && (result_status == STATUS_SINGULAR)
        |-> (point_x == '0) && (point_y == '0) && (point_z == '0))
    else $error("singular result with nonzero point");

    // The saturated status means some coordinate sits at a word limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && (result_status == STATUS_SATURATED)
        |-> (pt_reg[0] == SAT_MAX) || (pt_reg[0] == SAT_MIN)
         || (pt_reg[1] == SAT_MAX) || (pt_reg[1] == SAT_MIN)
         || (pt_reg[2] == SAT_MAX) || (pt_reg[2] == SAT_MIN))
    else $error("saturated status without a clamped coordinate");

    // A result held at the output must hold back the input side too.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |-> plane_stall)
    else $error("input accepted while output is stalled");

    // While the output is held, the result does not move.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> $stable(pt_reg[0]) && $stable(status_reg))
    else $error("held result changed");
`endif

endmodule

// ===== src/tpi_minor.sv =====
`timescale 1ns / 1ps

module tpi_minor
    import tpi_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [WORD_BITS-1:0]   coef_a [3],
    input  logic signed [WORD_BITS-1:0]   coef_b [3],
    input  logic signed [WORD_BITS-1:0]   coef_c [3],
    input  logic signed [WORD_BITS-1:0]   coef_d [3],
    output logic signed [2*WORD_BITS+2:0] minor [NUM_MINORS],
    output logic signed [WORD_BITS:0]     row0 [NUM_COLS]
);

    localparam int CW = WORD_BITS + 1;
    localparam int PW = 2 * CW;
    localparam int MW = PW + 1;

    logic signed [CW-1:0] col [NUM_COLS][3];

    logic signed [PW-1:0] prod_reg  [NUM_MINORS][2];
    logic signed [PW-1:0] prod_next [NUM_MINORS][2];
    logic signed [CW-1:0] row0_s1_reg  [NUM_COLS];
    logic signed [CW-1:0] row0_s1_next [NUM_COLS];
    logic signed [MW-1:0] minor_reg  [NUM_MINORS];
    logic signed [MW-1:0] minor_next [NUM_MINORS];
    logic signed [CW-1:0] row0_s2_reg  [NUM_COLS];
    logic signed [CW-1:0] row0_s2_next [NUM_COLS];

    // The constant term moves to the right side, so its column is negated.
    // One extra bit keeps the negation of the most negative word exact.
    always_comb
    begin
        for (int p = 0; p < 3; p++)
        begin
            col[COL_A][p] = CW'(coef_a[p]);
            col[COL_B][p] = CW'(coef_b[p]);
            col[COL_C][p] = CW'(coef_c[p]);
            col[COL_E][p] = -CW'(coef_d[p]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_MINORS; k++)
        begin
            prod_next[k][0] = PW'(col[MINOR_X[k]][1]) * PW'(col[MINOR_Y[k]][2]);
            prod_next[k][1] = PW'(col[MINOR_Y[k]][1]) * PW'(col[MINOR_X[k]][2]);
        end
        for (int c = 0; c < NUM_COLS; c++)
        begin
            row0_s1_next[c] = col[c][0];
            row0_s2_next[c] = row0_s1_reg[c];
        end
        for (int k = 0; k < NUM_MINORS; k++)
        begin
            minor_next[k] = MW'(prod_reg[k][0]) - MW'(prod_reg[k][1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= prod_next;
            row0_s1_reg <= row0_s1_next;
            minor_reg   <= minor_next;
            row0_s2_reg <= row0_s2_next;
        end
    end

    assign minor = minor_reg;
    assign row0  = row0_s2_reg;

endmodule

// ===== src/tpi_expand.sv =====
`timescale 1ns / 1ps

module tpi_expand
    import tpi_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [2*WORD_BITS+2:0] minor [NUM_MINORS],
    input  logic signed [WORD_BITS:0]     row0 [NUM_COLS],
    output logic signed [3*WORD_BITS+5:0] sums [NUM_SUMS]
);

    localparam int CW  = WORD_BITS + 1;
    localparam int MW  = 2 * CW + 1;
    localparam int LW  = CW;
    localparam int PPW = 2 * CW + 1;
    localparam int TW  = CW + MW;
    localparam int DW  = 3 * CW + 3;

    logic signed [PPW-1:0] pp_lo_reg  [NUM_TERMS];
    logic signed [PPW-1:0] pp_lo_next [NUM_TERMS];
    logic signed [PPW-1:0] pp_hi_reg  [NUM_TERMS];
    logic signed [PPW-1:0] pp_hi_next [NUM_TERMS];
    logic signed [TW-1:0]  term_reg  [NUM_TERMS];
    logic signed [TW-1:0]  term_next [NUM_TERMS];
    logic signed [DW-1:0]  sum_reg  [NUM_SUMS];
    logic signed [DW-1:0]  sum_next [NUM_SUMS];

    // Each coefficient times minor product is split into a low half (unsigned)
    // and a high half (signed) so that no multiplier is much wider than a word.
    always_comb
    begin
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            pp_lo_next[t] = PPW'(row0[TERM_COEF[t]])
                          * PPW'($signed({1'b0, minor[TERM_MINOR[t]][LW-1:0]}));
            pp_hi_next[t] = PPW'(row0[TERM_COEF[t]])
                          * PPW'($signed(minor[TERM_MINOR[t]][MW-1:LW]));
            term_next[t]  = (TW'(pp_hi_reg[t]) <<< LW) + TW'(pp_lo_reg[t]);
        end
    end

    always_comb
    begin
        for (int s = 0; s < NUM_SUMS; s++)
        begin
            sum_next[s] = '0;
            for (int i = 0; i < 3; i++)
            begin
                if (TERM_NEG[3*s+i])
                    sum_next[s] = sum_next[s] - DW'(term_reg[3*s+i]);
                else
                    sum_next[s] = sum_next[s] + DW'(term_reg[3*s+i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            term_reg  <= term_next;
            sum_reg   <= sum_next;
        end
    end

    assign sums = sum_reg;

endmodule

// ===== src/tpi_div.sv =====
`timescale 1ns / 1ps

module tpi_div
    import tpi_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [3*WORD_BITS+5:0] num_mag,
    input  logic [3*WORD_BITS+5:0] den_mag,
    input  logic                   neg,
    output logic [WORD_BITS-1:0]   quo,
    output logic                   ovf,
    output logic                   quo_neg
);

    localparam int DW  = 3 * WORD_BITS + 6;
    localparam int SHW = (WORD_BITS > FRAC_BITS) ? WORD_BITS : FRAC_BITS;
    localparam int RW  = DW + SHW;

    logic [RW-1:0]        rem_reg  [WORD_BITS];
    logic [RW-1:0]        rem_next [WORD_BITS];
    logic [DW-1:0]        den_reg  [WORD_BITS];
    logic [DW-1:0]        den_next [WORD_BITS];
    logic [WORD_BITS-1:0] q_reg    [WORD_BITS+1];
    logic [WORD_BITS-1:0] q_next   [WORD_BITS+1];
    logic                 ovf_reg  [WORD_BITS+1];
    logic                 ovf_next [WORD_BITS+1];
    logic                 neg_reg  [WORD_BITS+1];
    logic                 neg_next [WORD_BITS+1];

    // First stage: scale the numerator and flag a quotient that needs more
    // than a word. Each following stage then resolves one quotient bit.
    assign rem_next[0] = RW'(num_mag) << FRAC_BITS;
    assign den_next[0] = den_mag;
    assign q_next[0]   = '0;
    assign ovf_next[0] = (RW'(num_mag) << FRAC_BITS) >= (RW'(den_mag) << WORD_BITS);
    assign neg_next[0] = neg;

    for (genvar j = 1; j <= WORD_BITS; j++)
    begin : g_stage
        localparam int K = WORD_BITS - j;
        logic [RW-1:0] shifted;
        logic          ge;

        assign shifted     = RW'(den_reg[j-1]) << K;
        assign ge          = rem_reg[j-1] >= shifted;
        assign q_next[j]   = q_reg[j-1] | (ge ? (WORD_BITS'(1) << K) : '0);
        assign ovf_next[j] = ovf_reg[j-1];
        assign neg_next[j] = neg_reg[j-1];

        if (j < WORD_BITS)
        begin : g_carry
            assign rem_next[j] = ge ? (rem_reg[j-1] - shifted) : rem_reg[j-1];
            assign den_next[j] = den_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_next;
            q_reg   <= q_next;
            ovf_reg <= ovf_next;
            neg_reg <= neg_next;
        end
    end

    assign quo     = q_reg[WORD_BITS];
    assign ovf     = ovf_reg[WORD_BITS];
    assign quo_neg = neg_reg[WORD_BITS];

endmodule
